// ===== rtl/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg: shared definitions for the radix-k digit converter
// Widths, limits and the structs that travel along the cell chain.
// ----------------------------------------------------------------------------
package rdc_pkg;

    // Sizing of the converter
    localparam int MAX_DIGITS   = 32;
    localparam int VALUE_BITS   = 31;
    localparam int RESULT_LIMIT = 32;

    // Effective digit count limit
    localparam int DIGIT_CAP    = (MAX_DIGITS < RESULT_LIMIT) ? MAX_DIGITS : RESULT_LIMIT;

    // Field widths
    localparam int RADIX_W      = 9;
    localparam int COUNT_W      = 6;
    localparam int DIGIT_W      = 8;
    localparam int POS_W        = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 9;

    // Conversion cycle counter must reach VALUE_BITS + MAX_DIGITS
    localparam int CYC_W        = $clog2(VALUE_BITS + MAX_DIGITS + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 1'd1;

    // Radix limits
    localparam logic [RADIX_W-1:0] RADIX_MIN = 9'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 9'd256;

    // Reset values of the registers
    localparam logic [RADIX_W-1:0] RADIX_RST = 9'd2;
    localparam logic [COUNT_W-1:0] COUNT_RST = 6'd8;

    // Carry wave between neighboring cells
    typedef struct packed {
        logic valid;
        logic carry;
    } link_t;

    // Per-cycle command to every cell
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== rtl/rdc_if.sv =====
// ----------------------------------------------------------------------------
// rdc_if: channel interfaces of the radix-k digit converter
// Input channel carries one value; output channel carries one digit.
// ----------------------------------------------------------------------------
interface rdc_in_if;
    logic                           valid;
    logic                           ready;
    logic [rdc_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rdc_out_if;
    logic                        valid;
    logic                        ready;
    logic [rdc_pkg::DIGIT_W-1:0] digit;
    logic [rdc_pkg::POS_W-1:0]   position;
    logic                        last;
    logic                        overflow;

    modport source (output valid, output digit, output position, output last,
                    output overflow, input ready);
    modport sink   (input valid, input digit, input position, input last,
                    input overflow, output ready);
endinterface

// ===== rtl/rdc_cell.sv =====
// ----------------------------------------------------------------------------
// rdc_cell: one base-r digit of the converter chain
// Doubles its digit and adds the incoming carry on each wave step, passes
// the carry to the next cell, and shifts digits toward cell 0 on output.
// ----------------------------------------------------------------------------
module rdc_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rdc_pkg::cell_ctrl_t         ctrl,
    input  logic [rdc_pkg::RADIX_W-1:0] radix,
    input  rdc_pkg::link_t              link_in,
    input  logic [rdc_pkg::DIGIT_W-1:0] digit_in,
    output rdc_pkg::link_t              link_out,
    output logic [rdc_pkg::DIGIT_W-1:0] digit
);

    logic [rdc_pkg::DIGIT_W-1:0] digit_reg;
    logic [rdc_pkg::DIGIT_W-1:0] digit_next;
    rdc_pkg::link_t              link_reg;
    rdc_pkg::link_t              link_next;
    logic [rdc_pkg::RADIX_W-1:0] dbl;
    logic [rdc_pkg::RADIX_W-1:0] dbl_sub;
    logic                        wrap;

    // Double and add carry, reduce once by the radix
    always_comb
    begin
        dbl     = {digit_reg, link_in.carry};
        wrap    = (dbl >= radix);
        dbl_sub = dbl - radix;
    end

    // Select the next digit
    always_comb
    begin
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
        else if (link_in.valid)
        begin
            digit_next = wrap ? dbl_sub[rdc_pkg::DIGIT_W-1:0] : dbl[rdc_pkg::DIGIT_W-1:0];
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    // Pass the wave to the neighbor
    always_comb
    begin
        link_next.valid = link_in.valid;
        link_next.carry = link_in.valid & wrap;
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;
    assign digit    = digit_reg;

endmodule

// ===== rtl/radix_k_digit_converter.sv =====
// ----------------------------------------------------------------------------
// radix_k_digit_converter: integer to base-k digits, least significant first
// Output: first digit offered once the carry wave has left the whole
//   cell chain after the input transaction; then one digit per cycle
//   while the output channel is ready.
// Input: a new value is accepted only after the last digit of the
//   previous one has been taken, as the bit-serial carry wave through the
//   cell chain and the digit shift-out occupy the converter.
// Reset: idle, radix 2, digit count 8, no pending transaction.
// ----------------------------------------------------------------------------
module radix_k_digit_converter
(
    input  logic                           clk,
    input  logic                           rst_n,
    rdc_in_if.sink                         value_ch,
    rdc_out_if.source                      digit_ch,
    input  logic                           cfg_we,
    input  logic [rdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rdc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [rdc_pkg::RADIX_W-1:0]     radix_reg;
    logic [rdc_pkg::COUNT_W-1:0]     count_reg;
    logic [rdc_pkg::VALUE_BITS-1:0]  val_reg;
    logic [rdc_pkg::VALUE_BITS-1:0]  val_next;
    logic [rdc_pkg::CYC_W-1:0]       cyc_reg;
    logic [rdc_pkg::CYC_W-1:0]       cyc_next;
    logic [rdc_pkg::POS_W-1:0]       pos_reg;
    logic [rdc_pkg::POS_W-1:0]       pos_next;
    logic                            ovf_reg;
    logic                            ovf_next;

    logic [rdc_pkg::RADIX_W-1:0]     eff_radix;
    logic [rdc_pkg::COUNT_W-1:0]     eff_cnt;
    logic                            in_acc;
    logic                            out_acc;
    logic                            feed;
    logic                            conv_done;
    logic                            ovf_hit;
    logic                            is_last;
    rdc_pkg::cell_ctrl_t             ctrl;

    rdc_pkg::link_t                  link  [rdc_pkg::MAX_DIGITS+1];
    logic [rdc_pkg::DIGIT_W-1:0]     digits[rdc_pkg::MAX_DIGITS+1];

    // Saturate the configured radix and digit count
    always_comb
    begin
        if (radix_reg < rdc_pkg::RADIX_MIN)
        begin
            eff_radix = rdc_pkg::RADIX_MIN;
        end
        else if (radix_reg > rdc_pkg::RADIX_MAX)
        begin
            eff_radix = rdc_pkg::RADIX_MAX;
        end
        else
        begin
            eff_radix = radix_reg;
        end

        if (count_reg == '0)
        begin
            eff_cnt = rdc_pkg::COUNT_W'(1);
        end
        else if (count_reg > rdc_pkg::COUNT_W'(rdc_pkg::DIGIT_CAP))
        begin
            eff_cnt = rdc_pkg::COUNT_W'(rdc_pkg::DIGIT_CAP);
        end
        else
        begin
            eff_cnt = count_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= rdc_pkg::RADIX_RST;
            count_reg <= rdc_pkg::COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rdc_pkg::REG_RADIX:
                begin
                    radix_reg <= cfg_data[rdc_pkg::RADIX_W-1:0];
                end
                rdc_pkg::REG_DIGIT_COUNT:
                begin
                    count_reg <= cfg_data[rdc_pkg::COUNT_W-1:0];
                end
                default:
                begin
                    radix_reg <= radix_reg;
                end
            endcase
        end
    end

    // Handshakes and chain control; hold the conversion until the carry wave
    // has left the last cell of the chain
    assign value_ch.ready = (state_reg == ST_IDLE);
    assign in_acc         = value_ch.valid & value_ch.ready;
    assign out_acc        = digit_ch.valid & digit_ch.ready;
    assign feed           = (state_reg == ST_CONV) &&
                            (cyc_reg < rdc_pkg::CYC_W'(rdc_pkg::VALUE_BITS));
    assign conv_done      = (cyc_reg == rdc_pkg::CYC_W'(rdc_pkg::VALUE_BITS
                                                        + rdc_pkg::MAX_DIGITS - 1));
    assign is_last        = (pos_reg == rdc_pkg::POS_W'(eff_cnt - rdc_pkg::COUNT_W'(1)));
    assign ctrl.clear     = in_acc;
    assign ctrl.shift     = out_acc;

    // Feed value bits MSB first into cell 0
    assign link[0].valid  = feed;
    assign link[0].carry  = val_reg[rdc_pkg::VALUE_BITS-1];
    assign digits[rdc_pkg::MAX_DIGITS] = '0;

    // Watch the carry leaving the top used cell
    always_comb
    begin
        ovf_hit = 1'b0;
        for (int j = 1; j <= rdc_pkg::MAX_DIGITS; j++)
        begin
            if (rdc_pkg::COUNT_W'(j) == eff_cnt)
            begin
                ovf_hit = link[j].valid & link[j].carry;
            end
        end
    end

    // Cell chain
    for (genvar g = 0; g < rdc_pkg::MAX_DIGITS; g++)
    begin : g_cell
        rdc_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .radix    (eff_radix),
            .link_in  (link[g]),
            .digit_in (digits[g+1]),
            .link_out (link[g+1]),
            .digit    (digits[g])
        );
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        cyc_next   = cyc_reg;
        pos_next   = pos_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_CONV;
                    val_next   = value_ch.value;
                    cyc_next   = '0;
                    ovf_next   = 1'b0;
                end
            end
            ST_CONV:
            begin
                cyc_next = cyc_reg + rdc_pkg::CYC_W'(1);
                ovf_next = ovf_reg | ovf_hit;
                if (feed)
                begin
                    val_next = {val_reg[rdc_pkg::VALUE_BITS-2:0], 1'b0};
                end
                if (conv_done)
                begin
                    state_next = ST_EMIT;
                    pos_next   = '0;
                end
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    pos_next = pos_reg + rdc_pkg::POS_W'(1);
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cyc_reg   <= '0;
            pos_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cyc_reg   <= cyc_next;
            pos_reg   <= pos_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Value shift register
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    // Output transaction
    assign digit_ch.valid    = (state_reg == ST_EMIT);
    assign digit_ch.digit    = digits[0];
    assign digit_ch.position = pos_reg;
    assign digit_ch.last     = is_last;
    assign digit_ch.overflow = ovf_reg;

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        value_ch.ready |-> !digit_ch.valid)
        else $error("input ready while a digit is offered");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_ch.valid |-> ({1'b0, digit_ch.digit} < eff_radix))
        else $error("digit not below radix");

    a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && digit_ch.last) |=> value_ch.ready)
        else $error("not idle after last digit");

    a_wave_gone: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !link[rdc_pkg::MAX_DIGITS].valid)
        else $error("carry wave still in chain during output");

    a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_CONV && link[0].valid))
        else $error("conversion did not start");
`endif

endmodule
